// ===== src/cai_pkg.sv =====
// shared types and constants for the clock anomaly injector
// used by cai_alu, cai_table and clock_anomaly_injector; depends on nothing
`default_nettype none

package cai_pkg;

   localparam int TIME_W  = 64;
   localparam int COUNT_W = 32;
   localparam int CSR_W   = 1;

   localparam logic [1:0] OP_QUERY   = 2'd0;
   localparam logic [1:0] OP_ADD     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [1:0] KIND_JITTER = 2'd0;
   localparam logic [1:0] KIND_STALL  = 2'd1;
   localparam logic [1:0] KIND_JUMP   = 2'd2;

   localparam logic [CSR_W-1:0] CSR_BASE_TIME = 1'd0;
   localparam logic [CSR_W-1:0] CSR_TICK_STEP = 1'd1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [1:0]         anomaly_kind;
      logic [COUNT_W-1:0] fire_query;
      logic [TIME_W-1:0]  amount_bits;
      logic [COUNT_W-1:0] hold_count;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_value;
      logic [COUNT_W-1:0] queries_done;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COUNT_W-1:0] trigger;
      logic [TIME_W-1:0]  amount;
      logic [COUNT_W-1:0] hold;
   } entry_type;

   typedef enum logic [0:0] {
      ALU_ADD_SAT,
      ALU_ADD_SIGNED
   } alu_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== src/cai_alu.sv =====
// shared 64-bit saturating adder for tick, jump and jitter updates
// depends on cai_pkg
`default_nettype none

module cai_alu (
   input  wire cai_pkg::alu_op_type           op,
   input  wire logic [cai_pkg::TIME_W-1:0]    a,
   input  wire logic [cai_pkg::TIME_W-1:0]    b,
   output logic      [cai_pkg::TIME_W-1:0]    result
);

   logic [cai_pkg::TIME_W:0] sum;
   logic                     carry;

   assign sum   = {1'b0, a} + {1'b0, b};
   assign carry = sum[cai_pkg::TIME_W];

   always_comb begin
      unique case (op)
         cai_pkg::ALU_ADD_SAT: begin
            result = carry ? '1 : sum[cai_pkg::TIME_W-1:0];
         end
         cai_pkg::ALU_ADD_SIGNED: begin
            // negative b: a + b wraps (carry) exactly when a >= |b|, else floor at zero
            if (b[cai_pkg::TIME_W-1]) begin
               result = carry ? sum[cai_pkg::TIME_W-1:0] : '0;
            end else begin
               result = carry ? '1 : sum[cai_pkg::TIME_W-1:0];
            end
         end
         default: begin
            result = sum[cai_pkg::TIME_W-1:0];
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/cai_table.sv =====
// anomaly entry memory: one write port, one registered read port
// depends on cai_pkg
`default_nettype none

module cai_table #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  wire                       clock,
   input  wire logic                 wr_en,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire cai_pkg::entry_type   wr_data,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output cai_pkg::entry_type        rd_data
);

   cai_pkg::entry_type mem [DEPTH];
   cai_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/clock_anomaly_injector.sv =====
// top level: virtual clock with anomaly table, sequencer around one shared adder
// depends on cai_pkg, cai_alu, cai_table
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    cai_pkg::req_type
//   rsp_      out        rsp_valid/rsp_ready    cai_pkg::rsp_type
//   csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// a query goes from accept through a tick step, one walk step per stored entry through the
// single table read port and the shared adder, and a result load
// a stalled query, an add, a restart or an unused opcode goes straight to the result load
// one beat is in flight at a time; the next beat is taken while the result waits
// synchronous reset clears time to zero, the counters and the fill; entries are not cleared
// a stalled rsp_ holds the sequencer in its result state until the result register frees
`default_nettype none

module clock_anomaly_injector #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cai_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output cai_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cai_pkg::CSR_W-1:0]     csr_index,
   input  wire logic [cai_pkg::TIME_W-1:0]    csr_wdata
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   cai_pkg::state_type state_ff, state_in;

   logic [cai_pkg::TIME_W-1:0]  base_ff, tick_ff;
   logic [cai_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [cai_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [cai_pkg::COUNT_W-1:0] stall_ff, stall_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cai_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            rd_addr;
   cai_pkg::entry_type          wr_entry, rd_entry;

   cai_pkg::alu_op_type         alu_op;
   logic [cai_pkg::TIME_W-1:0]  alu_b, alu_result;

   logic                        req_fire;
   logic [cai_pkg::COUNT_W-1:0] count_next;
   logic                        walk_last;
   logic                        hit;

   assign req_ready = (state_ff == cai_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign count_next = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
   assign walk_last  = (FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff;
   assign hit        = (rd_entry.trigger == count_ff);

   assign wr_entry.kind    = req_data.anomaly_kind;
   assign wr_entry.trigger = req_data.fire_query;
   assign wr_entry.amount  = req_data.amount_bits;
   assign wr_entry.hold    = req_data.hold_count;

   cai_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   cai_alu u_alu (
      .op     (alu_op),
      .a      (now_ff),
      .b      (alu_b),
      .result (alu_result)
   );

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      stall_in     = stall_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_addr      = '0;
      alu_op       = cai_pkg::ALU_ADD_SAT;
      alu_b        = tick_ff;

      unique case (state_ff)
         cai_pkg::ST_IDLE: begin
            if (req_fire) begin
               status_in = cai_pkg::STATUS_OK;
               state_in  = cai_pkg::ST_RESP;
               unique case (req_data.opcode)
                  cai_pkg::OP_QUERY: begin
                     if (stall_ff != '0) begin
                        stall_in = stall_ff - 1'b1;
                        count_in = count_next;
                     end else begin
                        state_in = cai_pkg::ST_TICK;
                     end
                  end
                  cai_pkg::OP_ADD: begin
                     if (fill_ff == FILL_W'(TABLE_DEPTH)) begin
                        status_in = cai_pkg::STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  cai_pkg::OP_RESTART: begin
                     now_in   = base_ff;
                     count_in = '0;
                     stall_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         cai_pkg::ST_TICK: begin
            // query number zero keeps the time; entry 0 read is issued here
            if (count_ff != '0) begin
               now_in = alu_result;
            end
            idx_in = '0;
            if (fill_ff == '0) begin
               count_in = count_next;
               state_in = cai_pkg::ST_RESP;
            end else begin
               state_in = cai_pkg::ST_WALK;
            end
         end
         cai_pkg::ST_WALK: begin
            // rd_entry holds entry idx_ff; prefetch the next one
            rd_addr = IDX_W'(idx_ff + IDX_W'(1));
            alu_b   = rd_entry.amount;
            alu_op  = (rd_entry.kind == cai_pkg::KIND_JITTER) ? cai_pkg::ALU_ADD_SIGNED
                                                               : cai_pkg::ALU_ADD_SAT;
            if (hit) begin
               case (rd_entry.kind) inside
                  cai_pkg::KIND_JITTER, cai_pkg::KIND_JUMP: now_in = alu_result;
                  cai_pkg::KIND_STALL:                      stall_in = rd_entry.hold;
                  default: begin
                  end
               endcase
            end
            idx_in = IDX_W'(idx_ff + IDX_W'(1));
            if (walk_last) begin
               count_in = count_next;
               state_in = cai_pkg::ST_RESP;
            end
         end
         cai_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.time_value   = now_ff;
               rsp_data_in.queries_done = count_ff;
               rsp_data_in.status       = status_ff;
               state_in                 = cai_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cai_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cai_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         count_ff     <= '0;
         stall_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         tick_ff      <= '0;
      end else begin
         now_ff       <= now_in;
         count_ff     <= count_in;
         stall_ff     <= stall_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               cai_pkg::CSR_BASE_TIME: base_ff <= csr_wdata;
               cai_pkg::CSR_TICK_STEP: tick_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
